// File: hdl/sact_pkg.sv
// Shared types, codes and constants of the cache tag controller.
package sact_pkg;

  localparam int SET_COUNT_DEF  = 128;
  localparam int LINE_BYTES_DEF = 32;
  localparam int MAX_WAYS_DEF   = 8;

  localparam logic [1:0] REQ_READ  = 2'd0;
  localparam logic [1:0] REQ_WRITE = 2'd1;
  localparam logic [1:0] REQ_FLUSH = 2'd2;
  localparam logic [1:0] REQ_PURGE = 2'd3;

  localparam logic [2:0] ST_HIT     = 3'd0;
  localparam logic [2:0] ST_MISS    = 3'd1;
  localparam logic [2:0] ST_UNCACHE = 3'd2;
  localparam logic [2:0] ST_MISALGN = 3'd3;
  localparam logic [2:0] ST_NOLINE  = 3'd4;

  localparam logic [2:0] BUS_NONE = 3'd0;
  localparam logic [2:0] BUS_RDSH = 3'd1;
  localparam logic [2:0] BUS_RDPR = 3'd2;
  localparam logic [2:0] BUS_UCRD = 3'd3;
  localparam logic [2:0] BUS_UCWR = 3'd4;

  // controller -> datapath
  typedef struct packed {
    logic capture;   // latch request, start way search
    logic clr_step;  // clearing pass: write entry, advance
    logic srch_step; // test one way
    logic finish;    // decide, update state, present result
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic clr_done;
    logic srch_done;
    logic bypass;    // uncached or misaligned: no lookup
  } dp_sts_t;

  // 0:2 ways, 1:4, 2:8; mode 3 acts as 0; clamp to max ways
  function automatic logic [1:0] eff_mode(input logic [1:0] m, input int max_ways);
    logic [1:0] r;
    r = (m == 2'd3) ? 2'd0 : m;
    if (r == 2'd2 && max_ways < 8) r = 2'd1;
    if (r == 2'd1 && max_ways < 4) r = 2'd0;
    return r;
  endfunction

  function automatic logic [2:0] plru_victim(input logic [1:0] mode, input logic [6:0] s);
    logic [2:0] v;
    if (mode == 2'd0) v = s[0] ? 3'd0 : 3'd1;
    else if (mode == 2'd1) begin
      if (!s[0]) v = s[2] ? 3'd2 : 3'd3;
      else       v = s[1] ? 3'd0 : 3'd1;
    end else begin
      if (!s[0]) begin
        if (!s[2]) v = s[6] ? 3'd6 : 3'd7;
        else       v = s[5] ? 3'd4 : 3'd5;
      end else begin
        if (!s[1]) v = s[4] ? 3'd2 : 3'd3;
        else       v = s[3] ? 3'd0 : 3'd1;
      end
    end
    return v;
  endfunction

  function automatic logic [6:0] plru_update(input logic [1:0] mode, input logic [6:0] s,
                                             input logic [2:0] w);
    logic [6:0] r;
    r = s;
    if (mode == 2'd0) r[0] = w[0];
    else if (mode == 2'd1) begin
      r[0] = w[1];
      r[1 + w[1]] = w[0];
    end else begin
      r[0] = w[2];
      r[1 + w[2]] = w[1];
      r[3 + w[2:1]] = w[0];
    end
    return r;
  endfunction

endpackage

// File: hdl/sact_ctrl.sv
// Sequencer: clearing pass, way search, result.
module sact_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  sact_pkg::dp_sts_t sts,
  output sact_pkg::dp_cmd_t cmd
);
  import sact_pkg::*;

  typedef enum logic [3:0] {
    S_CLEAR  = 4'b0001,
    S_IDLE   = 4'b0010,
    S_SEARCH = 4'b0100,
    S_DONE   = 4'b1000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_CLEAR;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    case (state)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_done) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          cmd.capture = 1'b1;
          state_next = S_SEARCH;
        end
      end
      S_SEARCH: begin
        if (sts.bypass || sts.srch_done) state_next = S_DONE;
        else cmd.srch_step = 1'b1;
      end
      S_DONE: begin
        cmd.finish = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_CLEAR;
    endcase
  end

  assign busy = (state != S_IDLE);
endmodule

// File: hdl/sact_dp.sv
// Tag, valid, modified and PLRU stores with lookup and update datapath.
module sact_dp #(
  parameter int SET_COUNT  = sact_pkg::SET_COUNT_DEF,
  parameter int LINE_BYTES = sact_pkg::LINE_BYTES_DEF,
  parameter int MAX_WAYS   = sact_pkg::MAX_WAYS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  sact_pkg::dp_cmd_t cmd,
  output sact_pkg::dp_sts_t sts,
  input  logic [1:0]        cfg_mode,
  input  logic [1:0]        req_type,
  input  logic [63:0]       address,
  input  logic [1:0]        size_code,
  input  logic              cacheable,
  output logic              done,
  output logic [2:0]        status,
  output logic [2:0]        way_used,
  output logic [6:0]        set_number,
  output logic [4:0]        line_offset,
  output logic              writeback_valid,
  output logic [63:0]       writeback_address,
  output logic [2:0]        bus_request
);
  import sact_pkg::*;

  localparam int OB = $clog2(LINE_BYTES);
  localparam int IB = $clog2(SET_COUNT);
  localparam int TB = 64 - OB - IB;
  localparam int WB = (MAX_WAYS > 4) ? 3 : ((MAX_WAYS > 2) ? 2 : 1);
  localparam int ENT = MAX_WAYS * SET_COUNT;
  localparam int EB = $clog2(ENT);
  // per-entry record: valid, modified, tag
  localparam int RB = TB + 2;

  logic [RB-1:0] line_mem [ENT];
  logic [6:0]    plru_mem [SET_COUNT];

  logic [EB:0]   clr_cnt;
  logic [1:0]    rq;
  logic [63:0]   ad;
  logic [1:0]    sz;
  logic          ca;
  logic [1:0]    mode;
  logic [WB:0]   wcnt;     // ways issued for reading
  logic          rd_vld;   // line_rd holds way wcnt-1
  logic [RB-1:0] line_rd;
  logic [6:0]    plru_rd;
  logic          hit;
  logic [WB-1:0] hit_way;
  logic [RB-1:0] hit_rec;
  logic [RB-1:0] vic_rec;  // record of the victim, captured during search
  logic [WB-1:0] vic_way;

  logic [IB-1:0] set_i;
  logic [TB-1:0] tag_i;
  logic [WB:0]   ways;
  logic          bypass;

  assign set_i = ad[OB +: IB];
  assign tag_i = ad[63 -: TB];
  assign ways  = (WB + 1)'(2) << mode;
  assign bypass = (rq[1] == 1'b0) &&
                  (!ca || ((ad[2:0] & ((3'd1 << sz) - 3'd1)) != 3'd0));

  assign sts.clr_done  = (clr_cnt == (EB + 1)'(ENT - 1));
  assign sts.bypass    = bypass;
  // last way's record is still pending while rd_vld is set
  assign sts.srch_done = hit || (!rd_vld && wcnt == ways);

  function automatic logic [EB-1:0] ent(input logic [WB-1:0] w, input logic [IB-1:0] s);
    return EB'(w) * EB'(SET_COUNT) + EB'(s);
  endfunction

  logic [WB-1:0] fin_way;
  logic [RB-1:0] fin_rec;
  assign vic_way = WB'(plru_victim(mode, plru_rd) & (3'(ways) - 3'd1));
  assign fin_way = hit ? hit_way : vic_way;
  assign fin_rec = hit ? hit_rec : vic_rec;

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
      done <= 1'b0;
    end else begin
      done <= cmd.finish;
      if (cmd.clr_step && !sts.clr_done) clr_cnt <= clr_cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.clr_step) begin
      line_mem[clr_cnt[EB-1:0]] <= '0;
      if (clr_cnt < (EB + 1)'(SET_COUNT)) plru_mem[clr_cnt[IB-1:0]] <= '0;
    end
    if (cmd.capture) begin
      rq <= req_type; ad <= address; sz <= size_code; ca <= cacheable;
      mode <= eff_mode(cfg_mode, MAX_WAYS);
      wcnt <= '0; rd_vld <= 1'b0; hit <= 1'b0; hit_way <= '0;
    end
    if (cmd.srch_step) begin
      if (wcnt < ways) begin
        line_rd <= line_mem[ent(wcnt[WB-1:0], set_i)];
        wcnt <= wcnt + 1'b1;
      end
      plru_rd <= plru_mem[set_i];
      rd_vld <= (wcnt < ways);
      if (rd_vld) begin
        if (line_rd[RB-1] && line_rd[TB-1:0] == tag_i) begin
          hit <= 1'b1; hit_way <= WB'(wcnt - 1'b1); hit_rec <= line_rd;
        end
      end
    end
    // victim record: captured from the search read of the victim way once the PLRU word is known
    if (cmd.srch_step && rd_vld && (WB'(wcnt - 1'b1) == vic_way)) vic_rec <= line_rd;

    if (cmd.finish) begin
      status <= ST_HIT; way_used <= '0; writeback_valid <= 1'b0;
      writeback_address <= '0; bus_request <= BUS_NONE;
      set_number <= 7'(ad[OB +: IB]);
      line_offset <= 5'(ad[OB-1:0]);
      if (rq[1] == 1'b0 && !ca) begin
        status <= ST_UNCACHE;
        bus_request <= (rq == REQ_READ) ? BUS_UCRD : BUS_UCWR;
      end else if (bypass) begin
        status <= ST_MISALGN;
      end else if (rq[1] == 1'b0) begin
        way_used <= 3'(fin_way);
        plru_mem[set_i] <= plru_update(mode, plru_rd, 3'(fin_way));
        if (!hit) begin
          status <= ST_MISS;
          bus_request <= (rq == REQ_READ) ? BUS_RDSH : BUS_RDPR;
          if (fin_rec[RB-1] && fin_rec[RB-2]) begin
            writeback_valid <= 1'b1;
            writeback_address <= {fin_rec[TB-1:0], set_i, OB'(0)};
          end
        end
        line_mem[ent(fin_way, set_i)] <=
          {1'b1, (rq == REQ_WRITE) || (hit && fin_rec[RB-2]), tag_i};
      end else if (hit) begin
        way_used <= 3'(hit_way);
        if (hit_rec[RB-2]) begin
          writeback_valid <= 1'b1;
          writeback_address <= {hit_rec[TB-1:0], set_i, OB'(0)};
        end
        line_mem[ent(hit_way, set_i)] <= (rq == REQ_PURGE) ? '0 :
                                         {1'b1, 1'b0, hit_rec[TB-1:0]};
      end else begin
        status <= ST_NOLINE;
      end
    end
  end
endmodule

// File: hdl/set_assoc_cache_tag_controller_core.sv
// Top level of the set-associative cache tag controller.
//  channel   direction  handshake            payload
//  request   in         start & !busy        req_type address size_code cacheable
//  result    out        done, one cycle      status way_used set_number line_offset
//                                            writeback_valid writeback_address bus_request
//  config    in         assoc_wr             assoc_wdata
// A cached lookup that misses runs from acceptance through the search to result:
// one way tag read per cycle, a final test of the last way, then a state update
// that registers the result. A hit in way k ends the search early;
// uncached and misaligned requests skip the search.
// After reset a clearing pass over all MAX_WAYS*SET_COUNT entries (1024 by default)
// sweeps the line memory; busy stays high meanwhile.
// Results are not stalled; done pulses for one cycle.
module set_assoc_cache_tag_controller_core #(
  parameter int SET_COUNT  = sact_pkg::SET_COUNT_DEF,
  parameter int LINE_BYTES = sact_pkg::LINE_BYTES_DEF,
  parameter int MAX_WAYS   = sact_pkg::MAX_WAYS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  req_type,
  input  logic [63:0] address,
  input  logic [1:0]  size_code,
  input  logic        cacheable,
  input  logic        assoc_wr,
  input  logic [1:0]  assoc_wdata,
  output logic        done,
  output logic [2:0]  status,
  output logic [2:0]  way_used,
  output logic [6:0]  set_number,
  output logic [4:0]  line_offset,
  output logic        writeback_valid,
  output logic [63:0] writeback_address,
  output logic [2:0]  bus_request
);
  import sact_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;
  logic [1:0] assoc_mode;

  always_ff @(posedge clk) begin
    if (rst) assoc_mode <= 2'd0;
    else if (assoc_wr) assoc_mode <= assoc_wdata;
  end

  sact_ctrl u_ctrl (.clk, .rst, .start, .busy, .sts, .cmd);

  sact_dp #(.SET_COUNT(SET_COUNT), .LINE_BYTES(LINE_BYTES), .MAX_WAYS(MAX_WAYS)) u_dp (
    .clk, .rst, .cmd, .sts, .cfg_mode(assoc_mode),
    .req_type, .address, .size_code, .cacheable,
    .done, .status, .way_used, .set_number, .line_offset,
    .writeback_valid, .writeback_address, .bus_request
  );
endmodule

// File: hdl/sact_checker.sv
// Port-level assertions for the tag controller, bound to the top level.
module sact_checker (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        done,
  input logic [2:0]  status,
  input logic        writeback_valid,
  input logic [63:0] writeback_address,
  input logic [2:0]  bus_request
);
  import sact_pkg::*;

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy) else $error("accepted transaction did not raise busy");
  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("done held longer than one cycle");
  a_wb_addr: assert property (@(posedge clk) disable iff (rst)
    (done && !writeback_valid) |-> (writeback_address == 64'd0))
    else $error("write-back address without write-back");
  a_uc_bus: assert property (@(posedge clk) disable iff (rst)
    (done && status == ST_UNCACHE) |-> (bus_request == BUS_UCRD || bus_request == BUS_UCWR))
    else $error("uncached result without uncached bus request");
endmodule

bind set_assoc_cache_tag_controller_core sact_checker u_chk (
  .clk, .rst, .start, .busy, .done, .status, .writeback_valid,
  .writeback_address, .bus_request
);

// File: bench/tb_top.sv
// Testbench for the cache tag controller: a tag/PLRU predictor checked against each result.
`timescale 1ns / 100ps

class cache_tag_scoreboard;
  typedef struct packed {
    logic [2:0]  status;
    logic [2:0]  way;
    logic [6:0]  set_idx;
    logic [4:0]  ofs;
    logic        wb;
    logic [63:0] wb_addr;
    logic [2:0]  bus;
  } lookup_t;

  logic [51:0] tags[1024];
  bit          valid[1024];
  bit          dirty[1024];
  logic [6:0]  tree[128];
  logic [1:0]  mode_reg;
  lookup_t     pending[$];
  int          errors;
  int          checked;
  int          hits, misses, wbs;

  function new();
    for (int i = 0; i < 1024; i++) begin
      tags[i] = '0;
      valid[i] = 0;
      dirty[i] = 0;
    end
    for (int i = 0; i < 128; i++) tree[i] = '0;
    mode_reg = 2'd0;
    errors = 0;
    checked = 0;
  endfunction

  function void set_mode(logic [1:0] m);
    mode_reg = m;
  endfunction

  function logic [2:0] victim_of(logic [1:0] m, logic [6:0] s);
    if (m == 2'd0) return s[0] ? 3'd0 : 3'd1;
    if (m == 2'd1) begin
      if (!s[0]) return s[2] ? 3'd2 : 3'd3;
      return s[1] ? 3'd0 : 3'd1;
    end
    if (!s[0]) begin
      if (!s[2]) return s[6] ? 3'd6 : 3'd7;
      return s[5] ? 3'd4 : 3'd5;
    end
    if (!s[1]) return s[4] ? 3'd2 : 3'd3;
    return s[3] ? 3'd0 : 3'd1;
  endfunction

  function logic [6:0] touch(logic [1:0] m, logic [6:0] s, logic [2:0] w);
    logic [6:0] r;
    r = s;
    if (m == 2'd0) r[0] = w[0];
    else if (m == 2'd1) begin
      r[0] = w[1];
      r[1 + w[1]] = w[0];
    end else begin
      r[0] = w[2];
      r[1 + w[2]] = w[1];
      r[3 + w[2:1]] = w[0];
    end
    return r;
  endfunction

  function void note_request(logic [1:0] req, logic [63:0] addr, logic [1:0] sz, logic cch);
    lookup_t     r;
    logic [1:0]  m;
    int          ways, e;
    bit          hit;
    logic [51:0] tag;
    r = '0;
    r.set_idx = addr[11:5];
    r.ofs = addr[4:0];
    tag = addr[63:12];
    m = (mode_reg == 2'd3) ? 2'd0 : mode_reg;
    ways = 2 << m;
    hit = 0;
    if (req <= sact_pkg::REQ_WRITE && !cch) begin
      r.status = sact_pkg::ST_UNCACHE;
      r.bus = (req == sact_pkg::REQ_READ) ? sact_pkg::BUS_UCRD : sact_pkg::BUS_UCWR;
    end else if (req <= sact_pkg::REQ_WRITE && (addr & ((64'd1 << sz) - 1)) != 0) begin
      r.status = sact_pkg::ST_MISALGN;
    end else begin
      for (int w = 0; w < ways; w++) begin
        e = w * 128 + r.set_idx;
        if (!hit && valid[e] && tags[e] == tag) begin
          hit = 1;
          r.way = 3'(w);
        end
      end
      if (req <= sact_pkg::REQ_WRITE) begin
        if (!hit) begin
          r.way = victim_of(m, tree[r.set_idx]) & 3'(ways - 1);
          e = r.way * 128 + r.set_idx;
          if (valid[e] && dirty[e]) begin
            r.wb = 1;
            r.wb_addr = {tags[e], r.set_idx, 5'd0};
          end
          tags[e] = tag;
          valid[e] = 1;
          dirty[e] = 0;
          r.status = sact_pkg::ST_MISS;
          r.bus = (req == sact_pkg::REQ_READ) ? sact_pkg::BUS_RDSH : sact_pkg::BUS_RDPR;
          misses++;
        end else hits++;
        e = r.way * 128 + r.set_idx;
        if (req == sact_pkg::REQ_WRITE) dirty[e] = 1;
        tree[r.set_idx] = touch(m, tree[r.set_idx], r.way);
      end else if (hit) begin
        e = r.way * 128 + r.set_idx;
        if (dirty[e]) begin
          r.wb = 1;
          r.wb_addr = {tags[e], r.set_idx, 5'd0};
          dirty[e] = 0;
        end
        if (req == sact_pkg::REQ_PURGE) begin
          valid[e] = 0;
          tags[e] = '0;
        end
      end else r.status = sact_pkg::ST_NOLINE;
    end
    if (!r.wb) r.way = (r.status == sact_pkg::ST_HIT || r.status == sact_pkg::ST_MISS)
                       ? r.way : 3'd0;
    if (r.wb) wbs++;
    pending.push_back(r);
  endfunction

  function void check_result(lookup_t got);
    lookup_t exp_r;
    checked++;
    if (pending.size() == 0) begin
      errors++;
      if (errors <= 10) $display("ERROR: unexpected result %p", got);
      return;
    end
    exp_r = pending.pop_front();
    if (got !== exp_r) begin
      errors++;
      if (errors <= 10) $display("ERROR: result %0d expected %p got %p", checked, exp_r, got);
    end
  endfunction
endclass

module tb_top;
  import sact_pkg::*;

  logic        clk = 0;
  logic        rst = 1;
  logic        start = 0;
  logic        busy;
  logic [1:0]  req_type = '0;
  logic [63:0] address = '0;
  logic [1:0]  size_code = '0;
  logic        cacheable = 0;
  logic        assoc_wr = 0;
  logic [1:0]  assoc_wdata = '0;
  logic        done;
  logic [2:0]  status, way_used, bus_request;
  logic [6:0]  set_number;
  logic [4:0]  line_offset;
  logic        writeback_valid;
  logic [63:0] writeback_address;

  cache_tag_scoreboard sb = new();
  int unsigned cycles = 0;
  logic [51:0] hot_tags[8];

  set_assoc_cache_tag_controller_core uut (.*);

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > 400000) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  always @(posedge clk)
    if (!rst && done)
      sb.check_result({status, way_used, set_number, line_offset,
                       writeback_valid, writeback_address, bus_request});

  task automatic send_request(logic [1:0] req, logic [63:0] addr, logic [1:0] sz, logic cch);
    @(negedge clk);
    start <= 1;
    req_type <= req;
    address <= addr;
    size_code <= sz;
    cacheable <= cch;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_request(req, addr, sz, cch);
    @(negedge clk);
    start <= 0;
  endtask

  task automatic drain();
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_mode(logic [1:0] m);
    drain();
    @(negedge clk);
    assoc_wr <= 1;
    assoc_wdata <= m;
    @(negedge clk);
    assoc_wr <= 0;
    sb.set_mode(m);
  endtask

  // small tag pool and few sets so lines conflict, evict and write back
  function automatic logic [63:0] pick_addr(logic [1:0] sz);
    logic [63:0] a;
    a = {hot_tags[$urandom_range(7)], 5'($urandom_range(3)), 2'd0, 5'($urandom)};
    if ($urandom_range(3) != 0) a = a & ~((64'd1 << sz) - 1);
    return a;
  endfunction

  task automatic random_phase(int n);
    logic [1:0] sz;
    int burst;
    burst = 0;
    for (int i = 0; i < n; i++) begin
      if (burst == 0) begin
        repeat ($urandom_range(6)) @(negedge clk);
        burst = $urandom_range(1, 12);
      end
      burst--;
      sz = 2'($urandom);
      if ($urandom_range(15) == 0)
        send_request(2'($urandom), {$urandom, $urandom}, sz, 1'($urandom));
      else
        send_request(2'($urandom_range(9) < 7 ? $urandom_range(1) : $urandom_range(3, 2)),
                     pick_addr(sz), sz, $urandom_range(9) != 0);
    end
  endtask

  initial begin
    for (int i = 0; i < 8; i++) hot_tags[i] = {$urandom, $urandom};
    hot_tags[0] = '0;
    hot_tags[1] = '1;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    // directed: each request type, extremes, uncached, misaligned, no-line
    send_request(REQ_READ, 64'h0, 2'd3, 1);
    send_request(REQ_WRITE, 64'h0, 2'd3, 1);
    send_request(REQ_WRITE, 64'hFFFF_FFFF_FFFF_FFF8, 2'd3, 1);
    send_request(REQ_READ, 64'h1000, 2'd0, 1);
    send_request(REQ_READ, 64'h2000, 2'd0, 1); // evicts a dirty line
    send_request(REQ_FLUSH, 64'hFFFF_FFFF_FFFF_FFFF, 2'd0, 0);
    send_request(REQ_FLUSH, 64'h2000, 2'd0, 1);
    send_request(REQ_WRITE, 64'h2004, 2'd2, 1);
    send_request(REQ_PURGE, 64'h2000, 2'd1, 0);
    send_request(REQ_PURGE, 64'h2000, 2'd1, 1);
    send_request(REQ_READ, 64'h3, 2'd1, 1);
    send_request(REQ_WRITE, 64'h6, 2'd2, 1);
    send_request(REQ_READ, 64'h7, 2'd3, 0);
    send_request(REQ_WRITE, 64'hFFFF_FFFF_FFFF_FFFF, 2'd3, 0);
    send_request(REQ_WRITE, 64'h0000_0000_0000_0FE0, 2'd0, 1);
    write_mode(2'd1);
    random_phase(130);
    write_mode(2'd2);
    random_phase(150);
    write_mode(2'd3);
    random_phase(100);
    write_mode(2'd0);
    random_phase(80);
    write_mode(2'd2);
    random_phase(75);
    drain();
    $display("Covered %0d results: %0d hits, %0d misses, %0d write-backs over all modes.",
             sb.checked, sb.hits, sb.misses, sb.wbs);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches, %0d results missing", sb.errors, sb.pending.size());
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
